// File: src/cjk_width_normalizer_core_macros.svh
// ----------------------------------------------------------------------------
// CJK width normaliser assertion macros
// Shared assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CJK_WIDTH_NORMALIZER_CORE_MACROS_SVH
`define CJK_WIDTH_NORMALIZER_CORE_MACROS_SVH

// plain property, checked at every clock edge out of reset
`define CJKWN_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("cjk width normaliser check failed");

// antecedent in one cycle, consequent in the next
`define CJKWN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cjk width normaliser sequence check failed");

`endif

// File: src/cjkwn_pkg.sv
// ----------------------------------------------------------------------------
// CJK width normaliser package
// Types, code point constants and kana lookup tables.
// ----------------------------------------------------------------------------
package cjkwn_pkg;

    localparam logic [15:0] FW_LO       = 16'hFF01;
    localparam logic [15:0] FW_HI       = 16'hFF5E;
    localparam logic [15:0] FW_SHIFT    = 16'hFEE0;
    localparam logic [15:0] HK_LO       = 16'hFF65;
    localparam logic [15:0] HK_HI       = 16'hFF9F;
    localparam logic [15:0] MARK_VOICED = 16'hFF9E;
    localparam logic [15:0] MARK_SEMI   = 16'hFF9F;
    localparam logic [15:0] CMB_LO      = 16'h30A6;
    localparam logic [15:0] CMB_HI      = 16'h30FD;

    // output queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [15:0] char_val;
        logic        last;
        logic        changed;
    } result_t;

    // up to two results per step, compacted towards slot 0
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } push_t;

    function automatic logic [15:0] kana_full(input logic [5:0] idx);
        logic [15:0] k;
        unique case (idx)
            6'd0:  k = 16'h30fb;  6'd1:  k = 16'h30f2;  6'd2:  k = 16'h30a1;
            6'd3:  k = 16'h30a3;  6'd4:  k = 16'h30a5;  6'd5:  k = 16'h30a7;
            6'd6:  k = 16'h30a9;  6'd7:  k = 16'h30e3;  6'd8:  k = 16'h30e5;
            6'd9:  k = 16'h30e7;  6'd10: k = 16'h30c3;  6'd11: k = 16'h30fc;
            6'd12: k = 16'h30a2;  6'd13: k = 16'h30a4;  6'd14: k = 16'h30a6;
            6'd15: k = 16'h30a8;  6'd16: k = 16'h30aa;  6'd17: k = 16'h30ab;
            6'd18: k = 16'h30ad;  6'd19: k = 16'h30af;  6'd20: k = 16'h30b1;
            6'd21: k = 16'h30b3;  6'd22: k = 16'h30b5;  6'd23: k = 16'h30b7;
            6'd24: k = 16'h30b9;  6'd25: k = 16'h30bb;  6'd26: k = 16'h30bd;
            6'd27: k = 16'h30bf;  6'd28: k = 16'h30c1;  6'd29: k = 16'h30c4;
            6'd30: k = 16'h30c6;  6'd31: k = 16'h30c8;  6'd32: k = 16'h30ca;
            6'd33: k = 16'h30cb;  6'd34: k = 16'h30cc;  6'd35: k = 16'h30cd;
            6'd36: k = 16'h30ce;  6'd37: k = 16'h30cf;  6'd38: k = 16'h30d2;
            6'd39: k = 16'h30d5;  6'd40: k = 16'h30d8;  6'd41: k = 16'h30db;
            6'd42: k = 16'h30de;  6'd43: k = 16'h30df;  6'd44: k = 16'h30e0;
            6'd45: k = 16'h30e1;  6'd46: k = 16'h30e2;  6'd47: k = 16'h30e4;
            6'd48: k = 16'h30e6;  6'd49: k = 16'h30e8;  6'd50: k = 16'h30e9;
            6'd51: k = 16'h30ea;  6'd52: k = 16'h30eb;  6'd53: k = 16'h30ec;
            6'd54: k = 16'h30ed;  6'd55: k = 16'h30ef;  6'd56: k = 16'h30f3;
            6'd57: k = 16'h3099;  6'd58: k = 16'h309a;
            default: k = 16'h0000;
        endcase
        return k;
    endfunction

    // offset added to 30A6+idx by a following voiced mark
    function automatic logic [6:0] voiced_add(input logic [6:0] idx);
        logic [6:0] a;
        unique case (idx)
            7'd0: a = 7'd78;
            7'd5, 7'd7, 7'd9, 7'd11, 7'd13, 7'd15, 7'd17, 7'd19, 7'd21,
            7'd23, 7'd25, 7'd27, 7'd30, 7'd32, 7'd34, 7'd41, 7'd44, 7'd47,
            7'd50, 7'd53, 7'd87: a = 7'd1;
            7'd73, 7'd74, 7'd75, 7'd76: a = 7'd8;
            default: a = 7'd0;
        endcase
        return a;
    endfunction

    // offset added to 30A6+idx by a following semi-voiced mark
    function automatic logic [6:0] semi_add(input logic [6:0] idx);
        logic [6:0] a;
        unique case (idx)
            7'd41, 7'd44, 7'd47, 7'd50, 7'd53: a = 7'd2;
            default: a = 7'd0;
        endcase
        return a;
    endfunction

endpackage

// File: src/cjkwn_step.sv
// ----------------------------------------------------------------------------
// CJK width normaliser step
// Normalises one character against the held-back character and emits results.
// ----------------------------------------------------------------------------
module cjkwn_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [15:0]         char_in,
    input  logic                term_end_in,
    output cjkwn_pkg::push_t    push
);
    import cjkwn_pkg::*;

    logic [15:0] held_char_reg, held_char_next;
    logic        held_valid_reg, held_valid_next;
    logic        changed_flag_reg, changed_flag_next;

    logic [15:0] c_norm;
    logic [15:0] merged_char;
    logic [15:0] hk_off;
    logic [15:0] held_off;
    logic [6:0]  add;
    logic        chg;
    logic        merged;
    logic        can_merge;
    logic        is_mark;
    result_t     slot_held;
    result_t     slot_new;

    always_comb
    begin
        hk_off      = char_in - HK_LO;
        held_off    = held_char_reg - CMB_LO;
        is_mark     = (char_in == MARK_VOICED) || (char_in == MARK_SEMI);
        can_merge   = is_mark && held_valid_reg &&
                      (held_char_reg >= CMB_LO) && (held_char_reg <= CMB_HI);
        add         = (char_in == MARK_SEMI) ? semi_add(held_off[6:0])
                                             : voiced_add(held_off[6:0]);
        merged_char = held_char_reg + {9'd0, add};

        c_norm = char_in;
        chg    = changed_flag_reg;
        merged = 1'b0;
        if ((char_in >= FW_LO) && (char_in <= FW_HI))
        begin
            c_norm = char_in - FW_SHIFT;
            chg    = 1'b1;
        end
        else if ((char_in >= HK_LO) && (char_in <= HK_HI))
        begin
            merged = can_merge && (add != 7'd0);
            if (!merged)
            begin
                c_norm = kana_full(hk_off[5:0]);
            end
            chg = 1'b1;
        end

        slot_held = '{char_val: held_char_reg, last: 1'b0, changed: 1'b0};
        slot_new  = '{char_val: c_norm, last: 1'b1, changed: chg};

        push              = '0;
        held_char_next    = held_char_reg;
        held_valid_next   = held_valid_reg;
        changed_flag_next = changed_flag_reg;

        if (fire)
        begin
            if (merged)
            begin
                // mark folds into the held character
                if (term_end_in)
                begin
                    push.v0           = 1'b1;
                    push.r0           = '{char_val: merged_char, last: 1'b1, changed: chg};
                    held_char_next    = '0;
                    held_valid_next   = 1'b0;
                    changed_flag_next = 1'b0;
                end
                else
                begin
                    held_char_next    = merged_char;
                    changed_flag_next = chg;
                end
            end
            else
            begin
                if (held_valid_reg)
                begin
                    push.v0 = 1'b1;
                    push.r0 = slot_held;
                    if (term_end_in)
                    begin
                        push.v1 = 1'b1;
                        push.r1 = slot_new;
                    end
                end
                else if (term_end_in)
                begin
                    push.v0 = 1'b1;
                    push.r0 = slot_new;
                end

                if (term_end_in)
                begin
                    held_char_next    = '0;
                    held_valid_next   = 1'b0;
                    changed_flag_next = 1'b0;
                end
                else
                begin
                    held_char_next    = c_norm;
                    held_valid_next   = 1'b1;
                    changed_flag_next = chg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_char_reg    <= '0;
            held_valid_reg   <= 1'b0;
            changed_flag_reg <= 1'b0;
        end
        else
        begin
            held_char_reg    <= held_char_next;
            held_valid_reg   <= held_valid_next;
            changed_flag_reg <= changed_flag_next;
        end
    end

endmodule

// File: src/cjkwn_outq.sv
// ----------------------------------------------------------------------------
// CJK width normaliser result queue
// Small queue taking up to two results a cycle and giving one to the stream.
// ----------------------------------------------------------------------------
module cjkwn_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  cjkwn_pkg::push_t    push,
    input  logic                pop,
    output logic                space_ok,
    output logic                head_valid,
    output cjkwn_pkg::result_t  head
);
    import cjkwn_pkg::*;

    result_t              mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [Q_PTR_W-1:0]   wr_ptr_inc;
    logic [Q_CNT_W-1:0]   n_push;
    logic                 do_pop;

    always_comb
    begin
        do_pop      = pop && (cnt_reg != '0);
        n_push      = Q_CNT_W'(push.v0) + Q_CNT_W'(push.v1);
        wr_ptr_inc  = wr_ptr_reg + Q_PTR_W'(1);
        wr_ptr_next = wr_ptr_reg + n_push[Q_PTR_W-1:0];
        rd_ptr_next = do_pop ? (rd_ptr_reg + Q_PTR_W'(1)) : rd_ptr_reg;
        cnt_next    = cnt_reg + n_push - Q_CNT_W'(do_pop);
    end

    // room for a full two-result step
    assign space_ok   = (cnt_reg <= Q_CNT_W'(Q_DEPTH - 2));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.v1)
        begin
            mem_reg[wr_ptr_inc] <= push.r1;
        end
    end

endmodule

// File: src/cjk_width_normalizer_core.sv
// ----------------------------------------------------------------------------
// CJK width normaliser core
// Folds fullwidth ASCII and halfwidth katakana to their normal widths.
//
// Input stream: one UTF-16 code unit per item on s_tdata, s_tlast marks the
// last character of a term. Output stream: one normalised character per item
// on m_tdata, m_tlast closes the output term, m_tuser is set on that last item
// when any character of the term was altered or merged.
// One character is held back so that a following halfwidth voiced or
// semi-voiced mark can merge into it; merged marks produce no output item.
// An item is registered on acceptance and then processed, once the queue has
// room, into a four-entry result queue whose entries are registered before
// they show on m_tvalid. Sustained rate is one item per cycle while the
// receiver keeps up; the queue admits a step only while two entries are free.
// A term end may release two items at once; they drain one per cycle while m_tready is high.
// If the receiver stalls, the queue fills and s_tready drops; nothing is lost.
// Reset empties the input register and queue and forgets the held character.
// ----------------------------------------------------------------------------
`include "cjk_width_normalizer_core_macros.svh"

module cjk_width_normalizer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] char_in
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] char_out
    output logic        m_tlast,
    output logic        m_tuser     // [0] term_changed
);
    import cjkwn_pkg::*;

    logic        in_valid_reg;
    logic [15:0] in_char_reg;
    logic        in_last_reg;
    logic        step_fire;
    logic        space_ok;
    logic        head_valid;
    push_t       push;
    result_t     head;

    assign step_fire = in_valid_reg && space_ok;
    assign s_tready  = !in_valid_reg || step_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    cjkwn_step u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (step_fire),
        .char_in     (in_char_reg),
        .term_end_in (in_last_reg),
        .push        (push)
    );

    cjkwn_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (m_tready),
        .space_ok   (space_ok),
        .head_valid (head_valid),
        .head       (head)
    );

    assign m_tvalid = head_valid;
    assign m_tdata  = head.char_val;
    assign m_tlast  = head.last;
    assign m_tuser  = head.changed;

    // change flag only ever rides on the closing item of a term
    `CJKWN_ASSERT(a_flag_on_last, !m_tvalid || !m_tuser || m_tlast)
    // a step is never taken into a queue without room for both results
    `CJKWN_ASSERT(a_push_room, !(push.v0 || push.v1) || space_ok)
    // two results only ever come out of a term end
    `CJKWN_ASSERT_NEXT(a_compact, step_fire && !in_last_reg, !($past(push.v1)))

endmodule
